// ----- rtl/ed3_pkg.sv -----
// shared types and constants of the edit-distance top-3 search
package ed3_pkg;

	localparam int MAX_LEN_DEF   = 32;
	localparam int MAX_WORDS_DEF = 65536;
	localparam int NRANK         = 3;
	localparam int CW            = 6;   // column value and length width
	localparam int IW            = 16;  // word index width

	typedef enum logic [1:0] {
		CMD_QCHAR = 2'd0,
		CMD_DCHAR = 2'd1,
		CMD_EOW   = 2'd2,
		CMD_EOQ   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		TK_NONE,
		TK_DCHAR,
		TK_LOAD,
		TK_RANK,
		TK_EOQ
	} tok_kind_t;

	// request travelling down the cell row
	typedef struct packed {
		tok_kind_t         kind;
		logic [7:0]        ch;
		logic              store;     // query char gets a slot
		logic [CW-1:0]     target;    // slot of the stored query char
		logic [CW-1:0]     left_old;  // column entry of the left cell before update
		logic [CW-1:0]     left_new;  // column entry of the left cell after update
		logic              ovf;       // overflow flag carried by end of query
	} token_t;

endpackage

// ----- rtl/edit_distance_top3_search.sv -----
// top level of the edit-distance top-3 search
//
// s_* channel takes requests: tdata[1:0] cmd, tdata[9:2] ch. A query is loaded
// char by char (cmd 0), dictionary words follow as chars (cmd 1) each closed by
// end of word (cmd 2), and end of query (cmd 3) brings three results on m_*,
// rank 0 first, tlast on the third.
// Every request enters a row of MAX_LEN cells, one per query position, and
// moves one cell per cycle while the row is not stalled; each cell updates
// its column entry as a dictionary char passes, so one request is taken per
// cycle unless the row is stalled. Results of an end of query start once it
// has passed every cell register and the ranking register, rank 0 first.
// While results are still pending, requests keep flowing; only a second end of
// query reaching the end of the row waits there, and s_tready drops until the
// three pending results are taken.
// Reset empties the query, the ranking, the word counter and the row; no
// clearing pass is needed.
module edit_distance_top3_search import ed3_pkg::*; #(
	parameter int MAX_LEN   = MAX_LEN_DEF,
	parameter int MAX_WORDS = MAX_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // cmd[1:0], ch[9:2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // rank[1:0], distance[7:2], word_index[23:8],
	                               // found[24], overflow[25]
	output logic        m_tlast
);

	token_t tok [MAX_LEN+1];
	logic   adv;
	logic   take;

	assign s_tready = adv;
	assign take     = s_tvalid && adv;

	ed3_head #(.MAX_LEN(MAX_LEN)) u_head (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.cmd    (s_tdata[1:0]),
		.ch     (s_tdata[9:2]),
		.tok_o  (tok[0])
	);

	for (genvar i = 1; i <= MAX_LEN; i++) begin : g_cell
		ed3_cell #(.IDX(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.tok_i  (tok[i-1]),
			.tok_o  (tok[i])
		);
	end

	ed3_rank #(.MAX_WORDS(MAX_WORDS)) u_rank (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok_i    (tok[MAX_LEN]),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- rtl/ed3_head.sv -----
// front of the row: decodes requests and tracks query length and word position
module ed3_head import ed3_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [1:0]  cmd,
	input  logic [7:0]  ch,
	output token_t      tok_o
);

	localparam logic [CW-1:0] MAX_LEN_V = CW'(MAX_LEN);

	logic [CW-1:0] qlen_q;
	logic [CW-1:0] wpos_q;
	logic          ovf_q;

	always_comb begin
		tok_o          = '0;
		tok_o.kind     = TK_NONE;
		tok_o.ch       = ch;
		tok_o.target   = qlen_q + CW'(1);
		tok_o.store    = (qlen_q < MAX_LEN_V);
		tok_o.left_old = wpos_q;
		tok_o.left_new = wpos_q + CW'(1);
		tok_o.ovf      = ovf_q;
		if (take) begin
			unique case (cmd_t'(cmd))
				CMD_QCHAR: tok_o.kind = TK_LOAD;
				CMD_DCHAR: begin
					if (wpos_q < MAX_LEN_V) tok_o.kind = TK_DCHAR;
				end
				CMD_EOW: begin
					// empty query ranks column entry zero, which is the word length
					tok_o.kind     = TK_RANK;
					tok_o.left_new = wpos_q;
				end
				CMD_EOQ: tok_o.kind = TK_EOQ;
				default: tok_o.kind = TK_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_q <= '0;
			wpos_q <= '0;
			ovf_q  <= 1'b0;
		end else if (take) begin
			unique case (cmd_t'(cmd))
				CMD_QCHAR: begin
					wpos_q <= '0;
					if (qlen_q < MAX_LEN_V) qlen_q <= qlen_q + CW'(1);
					else ovf_q <= 1'b1;
				end
				CMD_DCHAR: begin
					if (wpos_q < MAX_LEN_V) wpos_q <= wpos_q + CW'(1);
					else ovf_q <= 1'b1;
				end
				CMD_EOW: wpos_q <= '0;
				CMD_EOQ: begin
					qlen_q <= '0;
					wpos_q <= '0;
					ovf_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/ed3_cell.sv -----
// one query position: holds its query char and column entry, updates on passing requests
module ed3_cell import ed3_pkg::*; #(
	parameter int IDX = 1
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   adv,
	input  token_t tok_i,
	output token_t tok_o
);

	localparam logic [CW-1:0] IDX_V = CW'(IDX);

	logic [7:0]    qch_q;
	logic          act_q;
	logic          act_d;
	logic [CW-1:0] col_q;
	logic [CW-1:0] col_d;
	token_t        tok_d;
	token_t        tok_q;
	logic [CW:0]   sub_c;
	logic [CW:0]   del_c;
	logic [CW:0]   ins_c;
	logic [CW:0]   m1_c;
	logic [CW:0]   best_c;
	logic          wr_en;

	assign wr_en = adv && (tok_i.kind == TK_LOAD) && tok_i.store && (tok_i.target == IDX_V);
	assign sub_c = {1'b0, tok_i.left_old} + (CW+1)'(qch_q != tok_i.ch);
	assign del_c = {1'b0, col_q} + (CW+1)'(1);
	assign ins_c = {1'b0, tok_i.left_new} + (CW+1)'(1);
	assign m1_c  = (sub_c < del_c) ? sub_c : del_c;
	assign best_c = (m1_c < ins_c) ? m1_c : ins_c;

	always_comb begin
		tok_d = tok_i;
		col_d = col_q;
		act_d = act_q;
		case (tok_i.kind)
			TK_DCHAR: begin
				if (act_q) begin
					tok_d.left_old = col_q;
					tok_d.left_new = best_c[CW-1:0];
					col_d          = best_c[CW-1:0];
				end
			end
			TK_LOAD: begin
				col_d = IDX_V;
				if (tok_i.store && tok_i.target == IDX_V) act_d = 1'b1;
			end
			TK_RANK: begin
				// inactive cells pass the distance of the last active one
				if (act_q) tok_d.left_new = col_q;
				col_d = IDX_V;
			end
			TK_EOQ: begin
				col_d = IDX_V;
				act_d = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= IDX_V;
			act_q <= 1'b0;
			tok_q <= '0;
		end else if (adv) begin
			col_q <= col_d;
			act_q <= act_d;
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) qch_q <= tok_i.ch;
	end

	assign tok_o = tok_q;

endmodule

// ----- rtl/ed3_rank.sv -----
// tail of the row: top-3 ranking and the result output register
module ed3_rank import ed3_pkg::*; #(
	parameter int MAX_WORDS = MAX_WORDS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  token_t        tok_i,
	output logic          adv,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [31:0]   m_tdata,
	output logic          m_tlast
);

	localparam int WCW = $clog2(MAX_WORDS + 1);
	localparam logic [WCW-1:0] MAX_WORDS_V = WCW'(MAX_WORDS);

	logic [CW-1:0]  bd_q [NRANK];
	logic [IW-1:0]  bi_q [NRANK];
	logic [NRANK-1:0] bv_q;
	logic [WCW-1:0] wcnt_q;
	logic [WCW+IW-1:0] wext;
	logic [IW-1:0]  idx;
	logic [CW-1:0]  word_dist;
	logic           ins0, ins1, ins2;
	logic           take;

	logic [CW-1:0]  od_q [NRANK];
	logic [IW-1:0]  oi_q [NRANK];
	logic [NRANK-1:0] ov_q;
	logic           oovf_q;
	logic           busy_q;
	logic [1:0]     cnt_q;
	logic [1:0]     cnt_last;

	assign cnt_last = 2'(NRANK - 1);
	// an end of query waits at the tail until the previous results are gone
	assign adv  = !(busy_q && tok_i.kind == TK_EOQ);
	assign take = adv && (tok_i.kind != TK_NONE);
	assign word_dist = tok_i.left_new;
	assign wext = {{IW{1'b0}}, wcnt_q};
	assign idx  = wext[IW-1:0];

	assign ins0 = !bv_q[0] || (bd_q[0] > word_dist);
	assign ins1 = !ins0 && (!bv_q[1] || (bd_q[1] > word_dist));
	assign ins2 = !ins0 && !ins1 && (!bv_q[2] || (bd_q[2] > word_dist));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_q   <= '0;
			wcnt_q <= '0;
			busy_q <= 1'b0;
			cnt_q  <= '0;
			for (int k = 0; k < NRANK; k++) begin
				bd_q[k] <= '0;
				bi_q[k] <= '0;
			end
		end else begin
			if (busy_q && m_tready) begin
				if (cnt_q == cnt_last) begin
					busy_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					cnt_q <= cnt_q + 2'd1;
				end
			end
			if (take && tok_i.kind == TK_RANK && wcnt_q < MAX_WORDS_V) begin
				wcnt_q <= wcnt_q + WCW'(1);
				if (ins0) begin
					bd_q[2] <= bd_q[1];   bi_q[2] <= bi_q[1]; bv_q[2] <= bv_q[1];
					bd_q[1] <= bd_q[0];   bi_q[1] <= bi_q[0]; bv_q[1] <= bv_q[0];
					bd_q[0] <= word_dist; bi_q[0] <= idx;     bv_q[0] <= 1'b1;
				end else if (ins1) begin
					bd_q[2] <= bd_q[1];   bi_q[2] <= bi_q[1]; bv_q[2] <= bv_q[1];
					bd_q[1] <= word_dist; bi_q[1] <= idx;     bv_q[1] <= 1'b1;
				end else if (ins2) begin
					bd_q[2] <= word_dist; bi_q[2] <= idx;     bv_q[2] <= 1'b1;
				end
			end
			if (take && tok_i.kind == TK_EOQ) begin
				bv_q   <= '0;
				wcnt_q <= '0;
				busy_q <= 1'b1;
				cnt_q  <= '0;
				for (int k = 0; k < NRANK; k++) begin
					bd_q[k] <= '0;
					bi_q[k] <= '0;
				end
			end
		end
	end

	// result snapshot, empty ranks read as zero
	always_ff @(posedge clk) begin
		if (take && tok_i.kind == TK_EOQ) begin
			oovf_q <= tok_i.ovf;
			ov_q   <= bv_q;
			for (int k = 0; k < NRANK; k++) begin
				od_q[k] <= bv_q[k] ? bd_q[k] : '0;
				oi_q[k] <= bv_q[k] ? bi_q[k] : '0;
			end
		end
	end

	assign m_tvalid = busy_q;
	assign m_tlast  = (cnt_q == cnt_last);
	assign m_tdata  = {6'b0, oovf_q, ov_q[cnt_q], oi_q[cnt_q], od_q[cnt_q], cnt_q};

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != 2'd3)
		else $error("result counter out of range");
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(bv_q[1] |-> bv_q[0]) and (bv_q[2] |-> bv_q[1]))
		else $error("ranking has a hole");
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(bv_q[1] |-> bd_q[0] <= bd_q[1]) and (bv_q[2] |-> bd_q[1] <= bd_q[2]))
		else $error("ranking out of order");
	a_eoq_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(take && tok_i.kind == TK_EOQ) |=> (busy_q && cnt_q == 2'd0 && bv_q == '0))
		else $error("end of query did not start result output");

endmodule

// ----- sim/tb_edit_distance_top3_search.sv -----
// self-checking testbench of the edit-distance top-3 search with its own ranking predictor
`timescale 1ns / 100ps

module tb_edit_distance_top3_search import ed3_pkg::*; ();

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 400;
	localparam int RANDOM_ITEMS   = 260;
	localparam int DRAIN_CYCLES   = MAX_LEN_DEF + 16;

	typedef struct packed {
		logic [1:0]  rank;
		logic [5:0]  distance;
		logic [15:0] word_index;
		logic        found;
		logic        overflow;
		logic        last;
	} hit_t;

	typedef struct {
		cmd_t        cmd;
		logic [7:0]  ch;
		bit          typed;
		logic [5:0]  distance;
		logic [15:0] word_index;
		logic        found;
		logic        overflow;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // cmd[1:0], ch[9:2]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // rank[1:0], distance[7:2], word_index[23:8], found[24], overflow[25]
	logic        m_tlast;

	int   errors = 0;
	int   items_sent = 0;
	bit   calm = 1'b0;
	bit   hold_go = 1'b0;
	bit   typed_row = 1'b0;
	hit_t typed_hit;

	hit_t       ranked_q[$];
	logic [7:0] query_buf[$];
	logic [7:0] word_buf[$];
	dir_row_t   dir_rows[$];

	// predictor state
	logic [7:0] q_chars[MAX_LEN_DEF];
	int         q_len;
	int         col[MAX_LEN_DEF + 1];
	int         w_pos;
	int         w_cnt;
	int         b_dist[NRANK];
	int         b_idx[NRANK];
	bit         b_ok[NRANK];
	bit         ovf_seen;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	edit_distance_top3_search u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	function automatic void wipe_column();
		for (int i = 0; i <= MAX_LEN_DEF; i++) col[i] = i;
		w_pos = 0;
	endfunction

	function automatic void wipe_search();
		q_len = 0;
		wipe_column();
		w_cnt = 0;
		ovf_seen = 1'b0;
		for (int k = 0; k < NRANK; k++) begin
			b_dist[k] = 0;
			b_idx[k] = 0;
			b_ok[k] = 1'b0;
		end
	endfunction

	// one request through the predictor; end of query queues three ranked hits
	function automatic void search_step(cmd_t c, logic [7:0] ch);
		int   diag, above, sub, best, distance;
		bit   placed;
		hit_t h;
		case (c)
			CMD_QCHAR: begin
				if (w_pos != 0) wipe_column();
				if (q_len < MAX_LEN_DEF) begin
					q_chars[q_len] = ch;
					q_len++;
					col[q_len] = q_len;
				end else begin
					ovf_seen = 1'b1;
				end
			end
			CMD_DCHAR: begin
				if (w_pos >= MAX_LEN_DEF) begin
					ovf_seen = 1'b1;
				end else begin
					diag = col[0];
					col[0] = w_pos + 1;
					for (int i = 1; i <= q_len; i++) begin
						above = col[i];
						sub = diag + ((q_chars[i - 1] != ch) ? 1 : 0);
						best = (above + 1 < sub) ? above + 1 : sub;
						col[i] = (col[i - 1] + 1 < best) ? col[i - 1] + 1 : best;
						diag = above;
					end
					w_pos++;
				end
			end
			CMD_EOW: begin
				distance = col[q_len];
				if (w_cnt < MAX_WORDS_DEF) begin
					placed = 1'b0;
					for (int k = 0; k < NRANK; k++) begin
						if (!placed && (!b_ok[k] || b_dist[k] > distance)) begin
							for (int m = NRANK - 1; m > k; m--) begin
								b_dist[m] = b_dist[m - 1];
								b_idx[m] = b_idx[m - 1];
								b_ok[m] = b_ok[m - 1];
							end
							b_dist[k] = distance;
							b_idx[k] = w_cnt & 16'hFFFF;
							b_ok[k] = 1'b1;
							placed = 1'b1;
						end
					end
					w_cnt++;
				end
				wipe_column();
			end
			default: begin
				for (int k = 0; k < NRANK; k++) begin
					h.rank = 2'(k);
					h.distance = b_ok[k] ? 6'(b_dist[k]) : 6'd0;
					h.word_index = b_ok[k] ? 16'(b_idx[k]) : 16'd0;
					h.found = b_ok[k];
					h.overflow = ovf_seen;
					h.last = (k == NRANK - 1);
					ranked_q.push_back(h);
				end
				wipe_search();
			end
		endcase
	endfunction

	function automatic void check_hit(hit_t want);
		hit_t got;
		got.rank = m_tdata[1:0];
		got.distance = m_tdata[7:2];
		got.word_index = m_tdata[23:8];
		got.found = m_tdata[24];
		got.overflow = m_tdata[25];
		got.last = m_tlast;
		if (got.rank !== want.rank) begin
			$display("%0t: rank expected %0d got %0d", $time, want.rank, got.rank);
			errors++;
		end
		if (got.distance !== want.distance) begin
			$display("%0t: distance expected %0d got %0d", $time, want.distance, got.distance);
			errors++;
		end
		if (got.word_index !== want.word_index) begin
			$display("%0t: word_index expected %0d got %0d", $time, want.word_index,
				got.word_index);
			errors++;
		end
		if (got.found !== want.found) begin
			$display("%0t: found expected %0b got %0b", $time, want.found, got.found);
			errors++;
		end
		if (got.overflow !== want.overflow) begin
			$display("%0t: overflow expected %0b got %0b", $time, want.overflow, got.overflow);
			errors++;
		end
		if (got.last !== want.last) begin
			$display("%0t: tlast expected %0b got %0b", $time, want.last, got.last);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (ranked_q.size() == 0) begin
				$display("%0t: result expected none got %h", $time, m_tdata);
				errors++;
			end else begin
				check_hit(ranked_q.pop_front());
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			search_step(cmd_t'(s_tdata[1:0]), s_tdata[9:2]);
			if (typed_row && ranked_q[ranked_q.size() - NRANK] !== typed_hit) begin
				$display("%0t: nearest word expected %h got %h", $time, typed_hit,
					ranked_q[ranked_q.size() - NRANK]);
				errors++;
			end
		end
	end

	function automatic int pause_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [7:0] pick_char(bit wide);
		if (wide) return 8'($urandom_range(0, 255));
		return 8'(8'h61 + $urandom_range(0, 3));
	endfunction

	// called at a falling edge, returns at the falling edge after the request is taken
	task automatic send_req(input cmd_t c, input logic [7:0] ch, input bit rushed);
		int g;
		g = rushed ? 0 : pause_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, ch, c};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic random_query(input bit long_one);
		int  r, qn, nw, n, edits, p;
		bit  wide;
		wide = ($urandom_range(0, 3) == 0);
		r = $urandom_range(0, 99);
		if (long_one) qn = 35;
		else if (r < 85) qn = $urandom_range(0, 8);
		else if (r < 95) qn = $urandom_range(9, 31);
		else qn = $urandom_range(32, 38);
		query_buf.delete();
		repeat (qn) query_buf.push_back(pick_char(wide));
		foreach (query_buf[i]) send_req(CMD_QCHAR, query_buf[i], 1'b0);
		nw = long_one ? 2 : $urandom_range(0, 6);
		repeat (nw) begin
			r = $urandom_range(0, 99);
			word_buf.delete();
			if (long_one || r >= 92) begin
				n = $urandom_range(28, 40);
				repeat (n) word_buf.push_back(pick_char(wide));
			end else if (r < 50) begin
				// near miss of the query
				foreach (query_buf[i]) word_buf.push_back(query_buf[i]);
				edits = $urandom_range(0, 3);
				repeat (edits) begin
					p = $urandom_range(0, word_buf.size());
					case ($urandom_range(0, 2))
						0: if (word_buf.size() > 0) word_buf[p % word_buf.size()] = pick_char(wide);
						1: word_buf.insert(p, pick_char(wide));
						default: if (word_buf.size() > 0) word_buf.delete(p % word_buf.size());
					endcase
				end
			end else begin
				n = $urandom_range(0, 10);
				repeat (n) word_buf.push_back(pick_char(wide));
			end
			foreach (word_buf[i]) begin
				// query char in the middle of a word drops the partial word
				if ($urandom_range(0, 99) < 2) send_req(CMD_QCHAR, pick_char(wide), 1'b0);
				send_req(CMD_DCHAR, word_buf[i], 1'b0);
			end
			if ($urandom_range(0, 99) < 94) send_req(CMD_EOW, 8'($urandom_range(0, 255)), 1'b0);
		end
		if ($urandom_range(0, 99) < 8) send_req(CMD_DCHAR, pick_char(wide), 1'b0);
		if ($urandom_range(0, 99) < 3) send_req(CMD_QCHAR, pick_char(wide), 1'b0);
		send_req(CMD_EOQ, 8'($urandom_range(0, 255)), 1'b0);
	endtask

	// receiver: random pauses, calm stretches, and one long hold-off
	initial begin
		int idle_left, busy_left, hold_left;
		bit held;
		idle_left = 0;
		busy_left = 0;
		hold_left = 0;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 299) == 0) calm = !calm;
			if (hold_go && !held) begin
				hold_left = HOLD_CYCLES;
				held = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (idle_left > 0) begin
				idle_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (busy_left > 0) begin
					busy_left--;
				end else begin
					idle_left = pause_len();
					busy_left = $urandom_range(0, 8);
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int round, start;
		wipe_search();
		foreach (q_chars[i]) q_chars[i] = 8'd0;

		// empty search, empty word on empty query, then a small query with a
		// dropped partial word, an empty word and an open word at end of query
		dir_rows.push_back('{CMD_EOQ,   8'hFF, 1'b1, 6'd0, 16'd0, 1'b0, 1'b0});
		dir_rows.push_back('{CMD_EOW,   8'h00, 1'b0, 6'd0, 16'd0, 1'b0, 1'b0});
		dir_rows.push_back('{CMD_EOQ,   8'h5A, 1'b1, 6'd0, 16'd0, 1'b1, 1'b0});
		dir_rows.push_back('{CMD_QCHAR, 8'h00, 1'b0, 6'd0, 16'd0, 1'b0, 1'b0});
		dir_rows.push_back('{CMD_QCHAR, 8'hFF, 1'b0, 6'd0, 16'd0, 1'b0, 1'b0});
		dir_rows.push_back('{CMD_DCHAR, 8'hFF, 1'b0, 6'd0, 16'd0, 1'b0, 1'b0});
		dir_rows.push_back('{CMD_DCHAR, 8'h00, 1'b0, 6'd0, 16'd0, 1'b0, 1'b0});
		dir_rows.push_back('{CMD_EOW,   8'hAA, 1'b0, 6'd0, 16'd0, 1'b0, 1'b0});
		dir_rows.push_back('{CMD_DCHAR, 8'h00, 1'b0, 6'd0, 16'd0, 1'b0, 1'b0});
		dir_rows.push_back('{CMD_QCHAR, 8'h55, 1'b0, 6'd0, 16'd0, 1'b0, 1'b0});
		dir_rows.push_back('{CMD_DCHAR, 8'h00, 1'b0, 6'd0, 16'd0, 1'b0, 1'b0});
		dir_rows.push_back('{CMD_DCHAR, 8'hFF, 1'b0, 6'd0, 16'd0, 1'b0, 1'b0});
		dir_rows.push_back('{CMD_EOW,   8'h55, 1'b0, 6'd0, 16'd0, 1'b0, 1'b0});
		dir_rows.push_back('{CMD_EOW,   8'h00, 1'b0, 6'd0, 16'd0, 1'b0, 1'b0});
		dir_rows.push_back('{CMD_DCHAR, 8'h80, 1'b0, 6'd0, 16'd0, 1'b0, 1'b0});
		dir_rows.push_back('{CMD_EOQ,   8'h00, 1'b1, 6'd1, 16'd1, 1'b1, 1'b0});

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			typed_row = dir_rows[i].typed;
			typed_hit = '{2'd0, dir_rows[i].distance, dir_rows[i].word_index,
				dir_rows[i].found, dir_rows[i].overflow, 1'b0};
			send_req(dir_rows[i].cmd, dir_rows[i].ch, 1'b0);
		end
		typed_row = 1'b0;

		// back-to-back queries against a stalled receiver fill the row
		hold_go = 1'b1;
		repeat (8) begin
			send_req(CMD_QCHAR, 8'h61, 1'b1);
			send_req(CMD_QCHAR, 8'h62, 1'b1);
			send_req(CMD_DCHAR, 8'h61, 1'b1);
			send_req(CMD_DCHAR, 8'h63, 1'b1);
			send_req(CMD_EOW, 8'h00, 1'b1);
			send_req(CMD_EOQ, 8'hC3, 1'b1);
		end

		round = 0;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			random_query(round == 0);
			round++;
		end
		s_tvalid <= 1'b0;

		while (ranked_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
